// ===== rtl/core/bsrl_pkg.sv =====
// Shared types and constants for the backend selector (round robin / least connections).
// Depends on nothing; the top and the scan engine import it (bsrl_ram does not).
package bsrl_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam int IDX_FIELD_W  = 4;   // backend_index and chosen_index
  localparam int CONN_W       = 16;  // connection counts
  localparam int IN_DATA_W    = 24;  // backend_index, healthy_flag, connection_value
  localparam int OUT_DATA_W   = 8;   // chosen_index, found, rejected
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_MODE = 2'd0;

  typedef enum logic [1:0] {
    KIND_ADD        = 2'd0,
    KIND_SET_HEALTH = 2'd1,
    KIND_SET_CONN   = 2'd2,
    KIND_PICK       = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // Control from the sequencer to the scan engine.
  typedef struct packed {
    logic start;
    logic lc_mode;
  } scan_ctrl_t;

  // Status from the scan engine back to the sequencer.
  typedef struct packed {
    logic done;
    logic found;
  } scan_stat_t;

endpackage

// ===== rtl/core/backend_selector_rr_least_conn.sv =====
// Backend selector top: table sequencer, health and count RAMs, APB register, result register.
// Add and set requests give their result in the cycle after acceptance; a pick passes through
// SCAN (one table read per cycle) and HOLD before its result is registered.
// Add and set requests sustain one per cycle unless the result channel stalls; a pick holds the
// input through its scan (paced by the single read port of the table RAMs) and HOLD.
// Reset: rst_n (synchronous) clears live count, cursor, strategy mode and all handshake
// state; the table RAMs are not cleared, since only entries below live count are read.
module backend_selector_rr_least_conn
  import bsrl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] backend_index, [4] healthy_flag,
                                            // [20:5] connection_value, [23:21] zero
  input  logic [1:0]            in_tuser,   // [1:0] kind
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [3:0] chosen_index, [4] found,
                                            // [5] rejected, [7:6] zero
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (LC_W > IDX_FIELD_W) ? LC_W : IDX_FIELD_W;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  kind_t              kind;
  logic [IDX_FIELD_W-1:0] req_index;
  logic               req_health;
  logic [CONN_W-1:0]  req_conn;

  assign kind       = kind_t'(in_tuser);
  assign req_index  = in_tdata[3:0];
  assign req_health = in_tdata[4];
  assign req_conn   = in_tdata[20:5];

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [LC_W-1:0]    live_r,  live_nxt;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic               mode_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_FIELD_W-1:0] out_idx_r,   out_idx_nxt;
  logic                   out_found_r, out_found_nxt;
  logic                   out_rej_r,   out_rej_nxt;

  logic [IDX_W-1:0]   res_idx_r;
  logic               res_found_r;

  logic               out_free;
  logic               accept;
  logic               table_full;
  logic               index_ok;
  logic [CMP_W-1:0]   req_index_ext;
  logic [CMP_W-1:0]   live_ext;
  logic [CMP_W-1:0]   res_idx_ext;

  // table RAM ports
  logic               h_we, c_we;
  logic [IDX_W-1:0]   h_waddr, c_waddr;
  logic               h_wdata;
  logic [CONN_W-1:0]  c_wdata;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_health;
  logic [CONN_W-1:0]  rd_count;

  // scan engine
  scan_ctrl_t         scan_ctrl;
  scan_stat_t         scan_stat;
  logic [IDX_W-1:0]   scan_sel;
  logic [IDX_W-1:0]   scan_cursor_nxt;

  assign out_free      = !out_valid_r || out_tready;
  assign in_tready     = (state_r == ST_IDLE) && out_free;
  assign accept        = in_tvalid && in_tready;
  assign table_full    = (live_r == LC_W'(MAX_ENTRIES));
  assign req_index_ext = CMP_W'(req_index);
  assign live_ext      = CMP_W'(live_r);
  assign res_idx_ext   = CMP_W'(res_idx_r);
  // live count never exceeds the table depth, so this also bounds the RAM index
  assign index_ok      = (req_index_ext < live_ext);

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (kind == KIND_PICK)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_stat.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs (table writes, live count, cursor, scan start, result register)
  // Table writes happen only in IDLE, and a scan starts only from IDLE, so the
  // RAMs never see a read and a write of the same entry in one cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    h_we          = 1'b0;
    c_we          = 1'b0;
    h_waddr       = live_r[IDX_W-1:0];
    c_waddr       = live_r[IDX_W-1:0];
    h_wdata       = 1'b1;
    c_wdata       = '0;
    live_nxt      = live_r;
    cursor_nxt    = cursor_r;
    scan_ctrl     = '{start: 1'b0, lc_mode: mode_r};
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_found_nxt = out_found_r;
    out_rej_nxt   = out_rej_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_idx_nxt   = '0;
          out_found_nxt = 1'b0;
          out_rej_nxt   = 1'b0;
          case (kind)
            KIND_ADD: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_rej_nxt = 1'b1;
              end else begin
                // append a healthy entry with zero connections
                h_we        = 1'b1;
                c_we        = 1'b1;
                out_idx_nxt = live_ext[IDX_FIELD_W-1:0];
                live_nxt    = live_r + LC_W'(1);
              end
            end
            KIND_SET_HEALTH: begin
              out_valid_nxt = 1'b1;
              out_rej_nxt   = !index_ok;
              h_we          = index_ok;
              h_waddr       = req_index_ext[IDX_W-1:0];
              h_wdata       = req_health;
            end
            KIND_SET_CONN: begin
              out_valid_nxt = 1'b1;
              out_rej_nxt   = !index_ok;
              c_we          = index_ok;
              c_waddr       = req_index_ext[IDX_W-1:0];
              c_wdata       = req_conn;
            end
            KIND_PICK: begin
              // hold the result register; the scan delivers later
              scan_ctrl.start = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // advance the round-robin cursor past the picked entry
        if (scan_stat.done && scan_stat.found && !mode_r) begin
          cursor_nxt = scan_cursor_nxt;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = res_found_r ? res_idx_ext[IDX_FIELD_W-1:0] : '0;
          out_found_nxt = res_found_r;
          out_rej_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      live_r      <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_idx_r   <= out_idx_nxt;
    out_found_r <= out_found_nxt;
    out_rej_r   <= out_rej_nxt;
    if ((state_r == ST_SCAN) && scan_stat.done) begin
      res_idx_r   <= scan_sel;
      res_found_r <= scan_stat.found;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration register: strategy mode
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == CFG_ADDR_MODE)) begin
      mode_r <= cfg_pwdata[0];
    end
  end

  assign cfg_prdata = (cfg_paddr == CFG_ADDR_MODE) ? CFG_DATA_W'(mode_r) : '0;

  // ---------------------------------------------------------------------------
  // Table RAMs and scan engine
  // ---------------------------------------------------------------------------
  bsrl_ram #(
    .WIDTH (1),
    .DEPTH (MAX_ENTRIES)
  ) u_health_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_health)
  );

  bsrl_ram #(
    .WIDTH (CONN_W),
    .DEPTH (MAX_ENTRIES)
  ) u_count_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_count)
  );

  bsrl_scan #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (scan_ctrl),
    .live_count (live_r),
    .cursor     (cursor_r),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_health  (rd_health),
    .rd_count   (rd_count),
    .stat       (scan_stat),
    .sel_index  (scan_sel),
    .cursor_nxt (scan_cursor_nxt)
  );

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rej_r, out_found_r, out_idx_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LC_W'(MAX_ENTRIES))
    else $error("live count exceeds table depth");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != '0) |-> (LC_W'(cursor_r) < live_r))
    else $error("round-robin cursor outside live table");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(h_we || c_we))
    else $error("table written while a pick is in progress");

  a_pick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (kind == KIND_PICK)) |=> (state_r == ST_SCAN))
    else $error("accepted pick did not start a scan");
`endif

endmodule

// ===== rtl/core/bsrl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module bsrl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bsrl_scan.sv =====
// Pick engine: streams the live table out of the RAMs one entry per cycle and
// evaluates round-robin or least-connections selection. Depends on bsrl_pkg.
module bsrl_scan
  import bsrl_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  scan_ctrl_t                           ctrl,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     live_count,
  input  logic [$clog2(MAX_ENTRIES)-1:0]       cursor,
  output logic                                 rd_en,
  output logic [$clog2(MAX_ENTRIES)-1:0]       rd_addr,
  input  logic                                 rd_health,
  input  logic [CONN_W-1:0]                    rd_count,
  output scan_stat_t                           stat,
  output logic [$clog2(MAX_ENTRIES)-1:0]       sel_index,
  output logic [$clog2(MAX_ENTRIES)-1:0]       cursor_nxt
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int LC_W  = $clog2(MAX_ENTRIES + 1);

  logic              busy_r,     busy_nxt;
  logic [LC_W-1:0]   issued_r,   issued_nxt;
  logic [IDX_W-1:0]  addr_r,     addr_nxt;
  logic              chk_v_r,    chk_v_nxt;
  logic              have_r,     have_nxt;
  logic [IDX_W-1:0]  chk_addr_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [CONN_W-1:0] best_cnt_r;

  logic              issue;
  logic [LC_W-1:0]   addr_inc;
  logic [IDX_W-1:0]  addr_wrap;
  logic [LC_W-1:0]   chk_inc;
  logic              hit;
  logic              better;
  logic              all_seen;
  logic              done;

  always_comb begin
    issue     = busy_r && (issued_r < live_count);
    addr_inc  = LC_W'(addr_r) + LC_W'(1);
    addr_wrap = (addr_inc == live_count) ? '0 : addr_inc[IDX_W-1:0];
    chk_inc   = LC_W'(chk_addr_r) + LC_W'(1);
    hit       = chk_v_r && rd_health;
    better    = hit && (!have_r || (rd_count < best_cnt_r));
    all_seen  = !chk_v_r && !issue;
    done      = busy_r && (ctrl.lc_mode ? all_seen : (hit || all_seen));
  end

  always_comb begin
    busy_nxt   = busy_r;
    issued_nxt = issued_r;
    addr_nxt   = addr_r;
    chk_v_nxt  = chk_v_r;
    have_nxt   = have_r;
    if (ctrl.start) begin
      busy_nxt   = 1'b1;
      issued_nxt = '0;
      // least connections walks from entry 0 so a tie keeps the lowest index
      addr_nxt   = ctrl.lc_mode ? '0 : cursor;
      chk_v_nxt  = 1'b0;
      have_nxt   = 1'b0;
    end else if (busy_r) begin
      busy_nxt   = !done;
      issued_nxt = issued_r + LC_W'(issue);
      addr_nxt   = issue ? addr_wrap : addr_r;
      chk_v_nxt  = issue;
      have_nxt   = have_r || better;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      issued_r <= '0;
      addr_r   <= '0;
      chk_v_r  <= 1'b0;
      have_r   <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      issued_r <= issued_nxt;
      addr_r   <= addr_nxt;
      chk_v_r  <= chk_v_nxt;
      have_r   <= have_nxt;
    end
  end

  // Address of the entry whose read data is on the RAM outputs now, and the running best.
  always_ff @(posedge clk) begin
    chk_addr_r <= addr_r;
    if (busy_r && better) begin
      best_idx_r <= chk_addr_r;
      best_cnt_r <= rd_count;
    end
  end

  assign rd_en      = issue;
  assign rd_addr    = addr_r;
  assign stat.done  = done;
  assign stat.found = ctrl.lc_mode ? have_r : hit;
  assign sel_index  = ctrl.lc_mode ? best_idx_r : chk_addr_r;
  assign cursor_nxt = (chk_inc == live_count) ? '0 : chk_inc[IDX_W-1:0];

endmodule
